// ===== rtl/core/cabr_pkg.sv =====
package cabr_pkg;

    localparam int DISK_BLOCKS = 64;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAD   = 2'd2;

    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_FREE       = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BAD        = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SPARE      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_USED_SPARE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FILE       = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NO_SPACE   = 3'd1;
    localparam logic [2:0] ST_TABLE_FULL = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd3;
    localparam logic [2:0] ST_NO_SPARE   = 3'd4;

    localparam logic [6:0] MAX_LEN = 7'd64;

    typedef struct packed {
        logic [2:0] status;
        logic [5:0] start_block;
        logic [5:0] block_num;
        logic [5:0] target_block;
        logic       redirected;
        logic       last;
    } result_t;

endpackage

// ===== rtl/core/cabr_res_q.sv =====
// Single-entry result register parting the engine from the result channel.
module cabr_res_q
    import cabr_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t m_data
);
    logic    valid_reg;
    result_t data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
        end
    end

    // a push is only made when the slot is free or being emptied
    assign full    = valid_reg && !m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;
endmodule

// ===== rtl/core/contiguous_alloc_bad_block_remap.sv =====
// Contiguous file allocator with bad-block remapping to a spare pool. Block
// kinds sit in a one-port block memory, file and remap entries in their own
// memories, all with registered reads. After reset, and after any write of
// total_blocks or spare_blocks, the map is rebuilt by a sweep over all
// DISK_BLOCKS blocks during which no request or register write is taken; a
// bad_map write starts a read and write-back sweep over all blocks. An
// allocate does a first-fit scan of the blocks below the spare pool, then a
// marking pass over the run; a read scans the file table for the entry, then
// per block searches the remap table, looks up the block kind and, for a
// fresh bad block, scans the spare pool, before it emits the block; a result
// waiting in the output register stalls the engine.
module contiguous_alloc_bad_block_remap
    import cabr_pkg::*;
#(
    parameter int FILE_SLOTS  = 32,
    parameter int REMAP_SLOTS = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic [7:0]           s_file_id,
    input  logic [6:0]           s_length,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [5:0]           m_start_block,
    output logic [5:0]           m_block_num,
    output logic [5:0]           m_target_block,
    output logic                 m_redirected,
    output logic                 m_last
);
    localparam int BW  = (DISK_BLOCKS > 1) ? $clog2(DISK_BLOCKS) : 1;
    localparam int BCW = $clog2(DISK_BLOCKS + 1);
    localparam int FW  = (FILE_SLOTS > 1) ? $clog2(FILE_SLOTS) : 1;
    localparam int FCW = $clog2(FILE_SLOTS + 1);
    localparam int RW  = (REMAP_SLOTS > 1) ? $clog2(REMAP_SLOTS) : 1;
    localparam int RCW = $clog2(REMAP_SLOTS + 1);
    localparam int XW  = (BCW > 7) ? BCW + 1 : 8;

    typedef enum logic [13:0] {
        S_INIT   = 14'b00000000000001,
        S_IDLE   = 14'b00000000000010,
        S_BADFX  = 14'b00000000000100,
        S_ASCAN  = 14'b00000000001000,
        S_AMARK  = 14'b00000000010000,
        S_FSCAN  = 14'b00000000100000,
        S_FWAIT  = 14'b00000001000000,
        S_RSCAN  = 14'b00000010000000,
        S_KREAD  = 14'b00000100000000,
        S_KCHK   = 14'b00001000000000,
        S_PSCAN  = 14'b00010000000000,
        S_EMIT   = 14'b00100000000000,
        S_BWAIT  = 14'b01000000000000,
        S_REPLY  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [6:0]  total_reg;
    logic [6:0]  spare_reg;
    logic [63:0] bad_reg;

    // memories
    logic [KIND_W-1:0] kind_mem [DISK_BLOCKS];
    logic [7:0]        fid_mem  [FILE_SLOTS];
    logic [5:0]        fst_mem  [FILE_SLOTS];
    logic [6:0]        fln_mem  [FILE_SLOTS];
    logic [5:0]        rbad_mem [REMAP_SLOTS];
    logic [5:0]        rsp_mem  [REMAP_SLOTS];

    logic [KIND_W-1:0] kind_q;
    logic [7:0]        fid_q;
    logic [5:0]        fst_q;
    logic [6:0]        fln_q;
    logic [5:0]        rbad_q, rsp_q;

    logic              kwe;
    logic [BW-1:0]     kaddr;
    logic [KIND_W-1:0] kwdata;
    logic              fwe;
    logic [FW-1:0]     faddr;
    logic              rwe;
    logic [RW-1:0]     raddr;

    logic [FCW-1:0] ftot_reg;
    logic [RCW-1:0] rtot_reg;

    logic [BCW-1:0] ptr_reg, ptr_next;
    logic [BCW-1:0] aux_reg, aux_next;
    logic [6:0]     run_reg, run_next;
    logic           rdp_reg, rdp_next;   // a memory read is pending
    logic           hit_reg, hit_next;
    logic [7:0]     id_reg;
    logic [6:0]     len_reg, len_next;
    logic [5:0]     st_reg, st_next;
    logic [6:0]     idx_reg, idx_next;
    logic [5:0]     tgt_reg, tgt_next;
    logic           red_reg, red_next;
    logic [2:0]     rst_reg, rst_next;
    result_t        res_reg, res_next;

    logic    push, q_full;
    result_t m_data;

    logic [BCW-1:0] used;
    logic [BCW-1:0] pool;
    logic [BCW-1:0] spc;

    always_comb begin
        used = ({{(XW-7){1'b0}}, total_reg} < XW'(DISK_BLOCKS)) ?
               BCW'(total_reg) : BCW'(DISK_BLOCKS);
        spc  = ({{(XW-7){1'b0}}, spare_reg} < XW'(used)) ? BCW'(spare_reg) : used;
        pool = used - spc;
    end

    function automatic logic bad_bit(logic [63:0] m, logic [BCW-1:0] b);
        logic r;
        r = 1'b0;
        if (XW'(b) < XW'(64)) begin
            r = m[b[5:0]];
        end
        return r;
    endfunction

    // block memory
    always_ff @(posedge aclk) begin
        if (kwe) begin
            kind_mem[kaddr] <= kwdata;
        end
        kind_q <= kind_mem[kaddr];
    end

    always_ff @(posedge aclk) begin
        if (fwe) begin
            fid_mem[faddr] <= id_reg;
            fst_mem[faddr] <= st_reg;
            fln_mem[faddr] <= len_reg;
        end
        fid_q <= fid_mem[faddr];
        fst_q <= fst_mem[faddr];
        fln_q <= fln_mem[faddr];
    end

    // a new entry is only written from the pool scan, where aux holds the spare
    always_ff @(posedge aclk) begin
        if (rwe) begin
            rbad_mem[raddr] <= idx_reg[5:0] + st_reg;
            rsp_mem[raddr]  <= aux_reg[5:0];
        end
        rbad_q <= rbad_mem[raddr];
        rsp_q  <= rsp_mem[raddr];
    end

    wire cfg_fire = cfg_valid && cfg_ready;
    wire in_fire  = s_valid && s_ready;
    assign cfg_ready = (state_reg == S_IDLE);
    assign s_ready   = (state_reg == S_IDLE) && !cfg_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= 7'd64;
            spare_reg <= 7'd8;
            bad_reg   <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_TOTAL: total_reg <= cfg_data[6:0];
                REG_SPARE: spare_reg <= cfg_data[6:0];
                REG_BAD:   bad_reg   <= cfg_data;
                default:   ;
            endcase
        end
    end

    wire [5:0] cur_blk = idx_reg[5:0] + st_reg;

    always_comb begin
        state_next = state_reg;
        ptr_next = ptr_reg;
        aux_next = aux_reg;
        run_next = run_reg;
        rdp_next = 1'b0;
        hit_next = hit_reg;
        len_next = len_reg;
        st_next  = st_reg;
        idx_next = idx_reg;
        tgt_next = tgt_reg;
        red_next = red_reg;
        rst_next = rst_reg;
        res_next = res_reg;
        kwe = 1'b0;
        kaddr = ptr_reg[BW-1:0];
        kwdata = KIND_FREE;
        fwe = 1'b0;
        faddr = ptr_reg[FW-1:0];
        rwe = 1'b0;
        raddr = ptr_reg[RW-1:0];
        push = 1'b0;

        case (state_reg)
            S_INIT: begin
                kwe = 1'b1;
                if (ptr_reg >= pool && ptr_reg < used) begin
                    kwdata = KIND_SPARE;
                end else if (ptr_reg < pool && bad_bit(bad_reg, ptr_reg)) begin
                    kwdata = KIND_BAD;
                end
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == BCW'(DISK_BLOCKS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_BADFX: begin
                // read each block, marking listed bad ones below the pool
                if (!rdp_reg) begin
                    rdp_next = 1'b1;
                end else begin
                    if (ptr_reg < pool && bad_bit(bad_reg, ptr_reg) &&
                        (kind_q == KIND_FREE || kind_q == KIND_FILE)) begin
                        kwe = 1'b1;
                        kwdata = KIND_BAD;
                    end
                    ptr_next = ptr_reg + 1'b1;
                    if (ptr_reg == BCW'(DISK_BLOCKS - 1)) begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_IDLE: begin
                ptr_next = '0;
                if (cfg_fire) begin
                    if (cfg_index == REG_TOTAL || cfg_index == REG_SPARE) begin
                        state_next = S_INIT;
                    end else if (cfg_index == REG_BAD) begin
                        state_next = S_BADFX;
                    end
                end else if (in_fire) begin
                    len_next = s_length;
                    res_next = '0;
                    res_next.last = 1'b1;
                    if (!s_req_type) begin
                        run_next = '0;
                        if (FCW'(FILE_SLOTS) <= ftot_reg) begin
                            res_next.status = ST_TABLE_FULL;
                            state_next = S_REPLY;
                        end else if (s_length == 7'd0 || s_length > MAX_LEN) begin
                            res_next.status = ST_NO_SPACE;
                            state_next = S_REPLY;
                        end else if (pool == '0) begin
                            res_next.status = ST_NO_SPACE;
                            state_next = S_REPLY;
                        end else begin
                            state_next = S_ASCAN;
                        end
                    end else begin
                        hit_next = 1'b0;
                        if (ftot_reg == '0) begin
                            res_next.status = ST_NOT_FOUND;
                            state_next = S_REPLY;
                        end else begin
                            state_next = S_FSCAN;
                        end
                    end
                end
            end
            S_ASCAN: begin
                if (!rdp_reg) begin
                    rdp_next = 1'b1;
                end else begin
                    if (kind_q == KIND_FREE) begin
                        if (run_reg + 7'd1 == len_reg) begin
                            aux_next = ptr_reg + 1'b1 - BCW'(len_reg);
                            st_next = 6'(ptr_reg + 1'b1 - BCW'(len_reg));
                            ptr_next = ptr_reg + 1'b1 - BCW'(len_reg);
                            state_next = S_AMARK;
                        end else begin
                            run_next = run_reg + 7'd1;
                            ptr_next = ptr_reg + 1'b1;
                        end
                    end else begin
                        run_next = '0;
                        ptr_next = ptr_reg + 1'b1;
                    end
                    if (state_next == S_ASCAN && ptr_reg + 1'b1 >= pool) begin
                        res_next.status = ST_NO_SPACE;
                        state_next = S_REPLY;
                    end
                end
            end
            S_AMARK: begin
                kwe = 1'b1;
                kwdata = KIND_FILE;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg + 1'b1 == aux_reg + BCW'(len_reg)) begin
                    fwe = 1'b1;
                    faddr = ftot_reg[FW-1:0];
                    res_next.status = ST_OK;
                    res_next.start_block = st_reg;
                    state_next = S_REPLY;
                end
            end
            S_FSCAN: begin
                // last matching entry wins
                if (rdp_reg) begin
                    if (fid_q == id_reg) begin
                        hit_next = 1'b1;
                        st_next = fst_q;
                        len_next = fln_q;
                    end
                end
                if (ptr_reg < BCW'(ftot_reg) && ptr_reg < BCW'(FILE_SLOTS)) begin
                    rdp_next = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    state_next = S_FWAIT;
                end
            end
            S_FWAIT: begin
                idx_next = '0;
                ptr_next = '0;
                if (!hit_reg) begin
                    res_next.status = ST_NOT_FOUND;
                    state_next = S_REPLY;
                end else begin
                    tgt_next = st_reg;
                    red_next = 1'b0;
                    rst_next = ST_OK;
                    state_next = S_RSCAN;
                end
            end
            S_RSCAN: begin
                if (rdp_reg && rbad_q == cur_blk) begin
                    tgt_next = rsp_q;
                    red_next = 1'b1;
                end
                if (ptr_reg < BCW'(rtot_reg)) begin
                    rdp_next = 1'b1;
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    state_next = red_next ? S_EMIT : S_KREAD;
                end
            end
            S_KREAD: begin
                kaddr = BW'(cur_blk);
                state_next = S_KCHK;
            end
            S_KCHK: begin
                kaddr = BW'(cur_blk);
                if (kind_q == KIND_BAD && XW'(cur_blk) < XW'(DISK_BLOCKS)) begin
                    ptr_next = pool;
                    if (RCW'(REMAP_SLOTS) <= rtot_reg) begin
                        rst_next = ST_NO_SPARE;
                        state_next = S_EMIT;
                    end else begin
                        state_next = S_PSCAN;
                    end
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_PSCAN: begin
                if (rdp_reg && kind_q == KIND_SPARE) begin
                    kaddr = BW'(aux_reg);
                    kwe = 1'b1;
                    kwdata = KIND_USED_SPARE;
                    tgt_next = 6'(aux_reg);
                    red_next = 1'b1;
                    rwe = 1'b1;
                    raddr = rtot_reg[RW-1:0];
                    state_next = S_EMIT;
                end else if (ptr_reg < used) begin
                    rdp_next = 1'b1;
                    aux_next = ptr_reg;
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    rst_next = ST_NO_SPARE;
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!q_full) begin
                    push = 1'b1;
                    res_next.status = rst_reg;
                    res_next.start_block = st_reg;
                    res_next.block_num = cur_blk;
                    res_next.target_block = tgt_reg;
                    res_next.redirected = red_reg;
                    res_next.last = (idx_reg + 7'd1 == len_reg);
                    if (idx_reg + 7'd1 == len_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next = idx_reg + 7'd1;
                        state_next = S_BWAIT;
                    end
                end
            end
            S_BWAIT: begin
                ptr_next = '0;
                tgt_next = cur_blk;
                red_next = 1'b0;
                rst_next = ST_OK;
                state_next = S_RSCAN;
            end
            S_REPLY: begin
                if (!q_full) begin
                    push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // emit pushes its fields straight from the registers being built
    result_t push_data;
    always_comb begin
        push_data = res_reg;
        if (state_reg == S_EMIT) begin
            push_data = res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
            ptr_reg   <= '0;
            rdp_reg   <= 1'b0;
            ftot_reg  <= '0;
            rtot_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            rdp_reg   <= rdp_next;
            if (state_reg == S_INIT) begin
                ftot_reg <= '0;
                rtot_reg <= '0;
            end else begin
                if (fwe) ftot_reg <= ftot_reg + 1'b1;
                if (rwe) rtot_reg <= rtot_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        aux_reg <= aux_next;
        run_reg <= run_next;
        hit_reg <= hit_next;
        len_reg <= len_next;
        st_reg  <= st_next;
        idx_reg <= idx_next;
        tgt_reg <= tgt_next;
        red_reg <= red_next;
        rst_reg <= rst_next;
        res_reg <= res_next;
        if (in_fire) begin
            id_reg <= s_file_id;
        end
    end

    cabr_res_q u_res_q (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_data    (m_data)
    );

    assign m_status       = m_data.status;
    assign m_start_block  = m_data.start_block;
    assign m_block_num    = m_data.block_num;
    assign m_target_block = m_data.target_block;
    assign m_redirected   = m_data.redirected;
    assign m_last         = m_data.last;
endmodule

// ===== rtl/core/cabr_checker.sv =====
module cabr_checker
    import cabr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_status,
    input logic       m_redirected,
    input logic       m_last
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_NO_SPARE)
        else $error("bad status");

    a_red: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_redirected |-> m_status == ST_OK)
        else $error("redirected with error");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NO_SPACE || m_status == ST_TABLE_FULL ||
        m_status == ST_NOT_FOUND) |-> m_last)
        else $error("error not last");

    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last |-> !s_ready)
        else $error("request taken mid read");
endmodule

bind contiguous_alloc_bad_block_remap cabr_checker u_cabr_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_redirected(m_redirected), .m_last(m_last)
);
